FILE: rtl/ldbc_pkg.sv
// Shared types, codes and constants for the LED dimmer and button controller.
// Used by every RTL file of the block; it depends on nothing else.
`default_nettype none

package ldbc_pkg;

    localparam int LEVEL_W = 11;
    localparam int DUTY_W = 10;
    localparam int HOLD_W = 16;
    localparam int CLICK_W = 8;
    localparam int BREATH_W = 5;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 11'd2047;
    localparam logic [LEVEL_W-1:0] FULL_SCALE = 11'd1023;
    localparam logic [HOLD_W-1:0] HOLD_TOP = 16'hFFFF;

    localparam logic [15:0] SLEEP_TICKS_RST = 16'd5000;
    localparam logic [7:0] DOUBLE_CLICK_RST = 8'd200;
    localparam logic [14:0] LONG_PRESS_RST = 15'd2000;
    localparam logic [15:0] POWER_OFF_RST = 16'd20000;
    localparam logic [9:0] SWEEP_FLOOR_RST = 10'd80;
    localparam logic [9:0] BREATH_PEAK_RST = 10'd150;
    localparam logic [3:0] BREATH_DIV_RST = 4'd10;
    localparam logic [9:0] INIT_BRIGHT_RST = 10'd200;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_FADEIN = 3'd1,
        MODE_ON     = 3'd2,
        MODE_FADEOUT = 3'd3,
        MODE_ADJUST = 3'd4,
        MODE_LOWBAT = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        SLEEP_NONE = 2'd0,
        SLEEP_REQ  = 2'd1,
        STOP_REQ   = 2'd2
    } sleep_code_t;

    typedef enum logic [1:0] {
        WAKE_NONE  = 2'd0,
        WAKE_START = 2'd1,
        WAKE_STOP  = 2'd2
    } wake_code_t;

    typedef enum logic [1:0] {
        BATT_NONE      = 2'd0,
        BATT_LOW       = 2'd1,
        BATT_RECOVERED = 2'd2,
        BATT_UNUSED    = 2'd3
    } batt_code_t;

    typedef enum logic [1:0] {
        DUTY_KEEP,
        DUTY_ZERO,
        DUTY_DRIVE
    } duty_op_t;

    typedef enum logic [2:0] {
        CFG_SLEEP_TICKS  = 3'd0,
        CFG_DOUBLE_CLICK = 3'd1,
        CFG_LONG_PRESS   = 3'd2,
        CFG_POWER_OFF    = 3'd3,
        CFG_SWEEP_FLOOR  = 3'd4,
        CFG_BREATH_PEAK  = 3'd5,
        CFG_BREATH_DIV   = 3'd6,
        CFG_INIT_BRIGHT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] sleep_ticks;
        logic [7:0]  double_click_ticks;
        logic [14:0] long_press_ticks;
        logic [15:0] power_off_ticks;
        logic [9:0]  sweep_floor;
        logic [9:0]  breath_peak;
        logic [3:0]  breath_divider;
        logic [9:0]  initial_brightness;
    } cfg_t;

    typedef struct packed {
        logic       button_edge;
        logic       button_level;
        logic [1:0] battery_event;
    } tick_t;

    typedef struct packed {
        logic [DUTY_W-1:0] pwm_duty;
        logic              hold_enable;
        logic              hold_pulse;
        logic [1:0]        sleep_request;
        logic [1:0]        wake_timer_cmd;
        logic [2:0]        mode_now;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/led_dimmer_button_controller.sv
// Top level of the LED dimmer and button controller: input register, result register, handshakes.
// Depends on ldbc_pkg, ldbc_cfg and ldbc_core.
//
//   Channel  Direction  Handshake             Payload
//   in       to block   in_valid / in_ready   button_edge, button_level, battery_event
//   out      from block out_valid / out_ready pwm_duty, hold_enable, hold_pulse,
//                                             sleep_request, wake_timer_cmd, mode_now
//   cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One tick request is taken per cycle while out_ready is high; the result register holds its result.
// The tick update and the square-law duty run in one pass between the input register
// and the result register, so the sustained rate is one tick per cycle while out_ready is high.
// Reset loads the default register values and the idle state; no clearing pass is needed.
// A stalled output holds its result and the input register, and ready drops only when both are full.
`default_nettype none

module led_dimmer_button_controller
    import ldbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  button_edge,
    input  wire logic                  button_level,
    input  wire logic [1:0]            battery_event,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DUTY_W-1:0]          pwm_duty,
    output logic                       hold_enable,
    output logic                       hold_pulse,
    output logic [1:0]                 sleep_request,
    output logic [1:0]                 wake_timer_cmd,
    output logic [2:0]                 mode_now,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    in_valid_reg;
    result_t out_reg;
    result_t result;
    logic    out_valid_reg;
    logic    step;

    assign step = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    ldbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ldbc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .tick   (tick_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg.button_edge <= button_edge;
            tick_reg.button_level <= button_level;
            tick_reg.battery_event <= battery_event;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign pwm_duty = out_reg.pwm_duty;
    assign hold_enable = out_reg.hold_enable;
    assign hold_pulse = out_reg.hold_pulse;
    assign sleep_request = out_reg.sleep_request;
    assign wake_timer_cmd = out_reg.wake_timer_cmd;
    assign mode_now = out_reg.mode_now;

`ifndef SYNTHESIS
    a_pulse_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.hold_pulse |->
            out_reg.mode_now == MODE_IDLE && out_reg.pwm_duty == '0 && out_reg.hold_enable)
        else $error("hold pulse without idle mode, zero duty and hold high");

    a_wake_start_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.wake_timer_cmd == WAKE_START |->
            out_reg.sleep_request == STOP_REQ)
        else $error("wake timer start without a stop request");

    a_wake_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.wake_timer_cmd == WAKE_STOP |-> out_reg.hold_enable)
        else $error("battery recovery left the hold pin low");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("a processed tick did not reach the result register");
`endif

endmodule

`default_nettype wire

FILE: rtl/ldbc_cfg.sv
// Configuration register file of the LED dimmer and button controller.
// Depends on ldbc_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module ldbc_cfg
    import ldbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SLEEP_TICKS:  cfg_next.sleep_ticks = cfg_data;
                CFG_DOUBLE_CLICK: cfg_next.double_click_ticks = cfg_data[7:0];
                CFG_LONG_PRESS:   cfg_next.long_press_ticks = cfg_data[14:0];
                CFG_POWER_OFF:    cfg_next.power_off_ticks = cfg_data;
                CFG_SWEEP_FLOOR:  cfg_next.sweep_floor = cfg_data[9:0];
                CFG_BREATH_PEAK:  cfg_next.breath_peak = cfg_data[9:0];
                CFG_BREATH_DIV:   cfg_next.breath_divider = cfg_data[3:0];
                CFG_INIT_BRIGHT:  cfg_next.initial_brightness = cfg_data[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sleep_ticks <= SLEEP_TICKS_RST;
            cfg_reg.double_click_ticks <= DOUBLE_CLICK_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_RST;
            cfg_reg.power_off_ticks <= POWER_OFF_RST;
            cfg_reg.sweep_floor <= SWEEP_FLOOR_RST;
            cfg_reg.breath_peak <= BREATH_PEAK_RST;
            cfg_reg.breath_divider <= BREATH_DIV_RST;
            cfg_reg.initial_brightness <= INIT_BRIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ldbc_core.sv
// Controller state and the per-tick update: mode machine, button handler and square-law duty.
// Depends on ldbc_pkg; the tick is registered in the top level before it reaches this logic.
`default_nettype none

module ldbc_core
    import ldbc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire tick_t tick,
    input  wire cfg_t  cfg,
    output result_t    result
);

    mode_t                mode_reg, mode_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [LEVEL_W-1:0]   bright_reg, bright_next;
    logic                 sweep_down_reg, sweep_down_next;
    logic [BREATH_W-1:0]  breath_reg, breath_next;
    logic [HOLD_W-1:0]    hold_cnt_reg, hold_cnt_next;
    logic [CLICK_W-1:0]   click_reg, click_next;
    logic                 pending_reg, pending_next;
    logic [15:0]          idle_cnt_reg, idle_cnt_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;
    logic                 hold_reg, hold_next;

    duty_op_t             duty_op;
    logic [LEVEL_W-1:0]   drive_val;
    logic [DUTY_W-1:0]    drive_clamped;
    logic [2*DUTY_W-1:0]  drive_sq;
    logic                 pulse;
    sleep_code_t          sreq;
    wake_code_t           wcmd;

    always_comb
    begin
        mode_next = mode_reg;
        level_next = level_reg;
        bright_next = bright_reg;
        sweep_down_next = sweep_down_reg;
        breath_next = breath_reg;
        hold_cnt_next = hold_cnt_reg;
        click_next = click_reg;
        pending_next = pending_reg;
        idle_cnt_next = idle_cnt_reg;
        hold_next = hold_reg;
        duty_op = DUTY_KEEP;
        drive_val = '0;
        pulse = 1'b0;
        sreq = SLEEP_NONE;
        wcmd = WAKE_NONE;

        if (tick.button_edge)
        begin
            pending_next = 1'b1;
            idle_cnt_next = cfg.sleep_ticks;
        end

        unique case (batt_code_t'(tick.battery_event))
            BATT_LOW:
            begin
                mode_next = MODE_LOWBAT;
                hold_next = 1'b0;
                level_next = '0;
                sweep_down_next = 1'b0;
                duty_op = DUTY_ZERO;
            end
            BATT_RECOVERED:
            begin
                wcmd = WAKE_STOP;
                mode_next = MODE_IDLE;
                duty_op = DUTY_ZERO;
                hold_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        unique case (mode_next)
            MODE_IDLE, MODE_ON:
            begin
                if (idle_cnt_next > 16'd1)
                begin
                    idle_cnt_next = idle_cnt_next - 16'd1;
                end
                else
                begin
                    sreq = (mode_next == MODE_IDLE) ? STOP_REQ : SLEEP_REQ;
                end
            end
            MODE_FADEIN:
            begin
                if ({1'b0, level_next} + 12'd1 < {1'b0, bright_next})
                begin
                    level_next = level_next + 11'd1;
                    duty_op = DUTY_DRIVE;
                    drive_val = level_next;
                end
                else
                begin
                    if (level_next != LEVEL_TOP)
                    begin
                        level_next = level_next + 11'd1;
                    end
                    mode_next = MODE_ON;
                end
            end
            MODE_FADEOUT:
            begin
                if (level_next > 11'd1)
                begin
                    level_next = level_next - 11'd1;
                    duty_op = DUTY_DRIVE;
                    drive_val = level_next;
                end
                else
                begin
                    level_next = '0;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_ADJUST:
            begin
                if (sweep_down_next)
                begin
                    if (bright_next > {1'b0, cfg.sweep_floor})
                    begin
                        bright_next = bright_next - 11'd1;
                        duty_op = DUTY_DRIVE;
                        drive_val = bright_next;
                    end
                    else
                    begin
                        if (bright_next != '0)
                        begin
                            bright_next = bright_next - 11'd1;
                        end
                        sweep_down_next = 1'b0;
                    end
                end
                else
                begin
                    if (bright_next < FULL_SCALE)
                    begin
                        bright_next = bright_next + 11'd1;
                        duty_op = DUTY_DRIVE;
                        drive_val = bright_next;
                    end
                    else
                    begin
                        if (bright_next != LEVEL_TOP)
                        begin
                            bright_next = bright_next + 11'd1;
                        end
                        sweep_down_next = 1'b1;
                    end
                end
            end
            default:
            begin
                if (breath_next > {1'b0, cfg.breath_divider})
                begin
                    breath_next = '0;
                    if (sweep_down_next)
                    begin
                        if (level_next > 11'd1)
                        begin
                            level_next = level_next - 11'd1;
                            duty_op = DUTY_DRIVE;
                            drive_val = level_next;
                        end
                        else
                        begin
                            level_next = '0;
                            sweep_down_next = 1'b0;
                            wcmd = WAKE_START;
                            sreq = STOP_REQ;
                        end
                    end
                    else
                    begin
                        if (level_next < {1'b0, cfg.breath_peak})
                        begin
                            level_next = level_next + 11'd1;
                            duty_op = DUTY_DRIVE;
                            drive_val = level_next;
                        end
                        else
                        begin
                            if (level_next != LEVEL_TOP)
                            begin
                                level_next = level_next + 11'd1;
                            end
                            sweep_down_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    breath_next = breath_next + 5'd1;
                end
            end
        endcase

        if (pending_next && !tick.button_level)
        begin
            pending_next = 1'b0;
            if ({1'b0, hold_cnt_next} > {2'b00, cfg.long_press_ticks} + 17'd2)
            begin
                hold_cnt_next = '0;
                level_next = bright_next;
                duty_op = DUTY_DRIVE;
                drive_val = level_next;
                mode_next = MODE_ON;
            end
            else
            begin
                if (click_next != '0)
                begin
                    bright_next = FULL_SCALE;
                end
                else
                begin
                    click_next = cfg.double_click_ticks;
                end
                mode_next = (mode_next == MODE_IDLE) ? MODE_FADEIN : MODE_FADEOUT;
            end
        end
        else if (pending_next)
        begin
            if (hold_cnt_next != HOLD_TOP)
            begin
                hold_cnt_next = hold_cnt_next + 16'd1;
            end
            if (hold_cnt_next == {1'b0, cfg.long_press_ticks} + 16'd1 && mode_next == MODE_ON)
            begin
                mode_next = MODE_ADJUST;
                bright_next = level_next;
            end
            if (hold_cnt_next > cfg.power_off_ticks)
            begin
                pulse = 1'b1;
                pending_next = 1'b0;
                mode_next = MODE_IDLE;
                duty_op = DUTY_ZERO;
                hold_next = 1'b1;
            end
        end
        else
        begin
            hold_cnt_next = '0;
            if (click_next != '0)
            begin
                click_next = click_next - 8'd1;
            end
        end
    end

    assign drive_clamped = (drive_val > FULL_SCALE) ? FULL_SCALE[DUTY_W-1:0]
                                                    : drive_val[DUTY_W-1:0];
    assign drive_sq = drive_clamped * drive_clamped + 20'd1023;

    always_comb
    begin
        unique case (duty_op)
            DUTY_ZERO:  duty_next = '0;
            DUTY_DRIVE: duty_next = drive_sq[2*DUTY_W-1:DUTY_W];
            default:    duty_next = duty_reg;
        endcase
    end

    always_comb
    begin
        result.pwm_duty = duty_next;
        result.hold_enable = hold_next;
        result.hold_pulse = pulse;
        result.sleep_request = sreq;
        result.wake_timer_cmd = wcmd;
        result.mode_now = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            level_reg <= '0;
            bright_reg <= {1'b0, INIT_BRIGHT_RST};
            sweep_down_reg <= 1'b0;
            breath_reg <= '0;
            hold_cnt_reg <= '0;
            click_reg <= '0;
            pending_reg <= 1'b0;
            idle_cnt_reg <= SLEEP_TICKS_RST;
            duty_reg <= '0;
            hold_reg <= 1'b1;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            level_reg <= level_next;
            bright_reg <= bright_next;
            sweep_down_reg <= sweep_down_next;
            breath_reg <= breath_next;
            hold_cnt_reg <= hold_cnt_next;
            click_reg <= click_next;
            pending_reg <= pending_next;
            idle_cnt_reg <= idle_cnt_next;
            duty_reg <= duty_next;
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

FILE: dv/led_dimmer_button_controller_test.sv
// Self-checking testbench for led_dimmer_button_controller: directed and random tick
// requests against an in-file model of the dimmer, under several register settings.
// Depends on ldbc_pkg and the led_dimmer_button_controller RTL.
`timescale 1ns / 100ps

module led_dimmer_button_controller_test;
    import ldbc_pkg::*;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              button_edge = 1'b0;
    logic              button_level = 1'b0;
    logic [1:0]        battery_event = 2'd0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [DUTY_W-1:0] pwm_duty;
    logic              hold_enable;
    logic              hold_pulse;
    logic [1:0]        sleep_request;
    logic [1:0]        wake_timer_cmd;
    logic [2:0]        mode_now;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = 3'd0;
    logic [15:0]       cfg_data = 16'd0;

    led_dimmer_button_controller u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .button_edge(button_edge),
        .button_level(button_level),
        .battery_event(battery_event),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pwm_duty(pwm_duty),
        .hold_enable(hold_enable),
        .hold_pulse(hold_pulse),
        .sleep_request(sleep_request),
        .wake_timer_cmd(wake_timer_cmd),
        .mode_now(mode_now),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    cfg_t             regs;
    mode_t            mode_q;
    logic [10:0]      lvl;
    logic [10:0]      bright;
    logic             sweep_dn;
    logic [4:0]       breath_cnt;
    logic [15:0]      hold_cnt;
    logic [7:0]       click_win;
    logic             pending;
    logic [15:0]      idle_cnt;
    logic [9:0]       duty;
    logic             hold_pin;

    tick_t            button_ticks[$];
    result_t          pending_outputs[$];
    tick_t            cur;
    result_t          want;
    int               ticks_queued = 0;
    int               ticks_taken = 0;
    int               results_seen = 0;
    int               fail_count = 0;
    int               settings_used = 1;
    int               gap_left = 0;
    int               stall_left = 0;
    bit               calm = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [9:0] square_law(logic [10:0] v);
        logic [31:0] c;
        logic [31:0] sq;
        c = (v > FULL_SCALE) ? 32'd1023 : {21'd0, v};
        sq = c * c + 32'd1023;
        return sq[19:10];
    endfunction

    function automatic sleep_code_t count_idle(sleep_code_t code);
        if (idle_cnt > 16'd1)
        begin
            idle_cnt = idle_cnt - 16'd1;
            return SLEEP_NONE;
        end
        return code;
    endfunction

    function automatic void reset_dimmer();
        regs.sleep_ticks = SLEEP_TICKS_RST;
        regs.double_click_ticks = DOUBLE_CLICK_RST;
        regs.long_press_ticks = LONG_PRESS_RST;
        regs.power_off_ticks = POWER_OFF_RST;
        regs.sweep_floor = SWEEP_FLOOR_RST;
        regs.breath_peak = BREATH_PEAK_RST;
        regs.breath_divider = BREATH_DIV_RST;
        regs.initial_brightness = INIT_BRIGHT_RST;
        mode_q = MODE_IDLE;
        lvl = '0;
        bright = {1'b0, regs.initial_brightness};
        sweep_dn = 1'b0;
        breath_cnt = '0;
        hold_cnt = '0;
        click_win = '0;
        pending = 1'b0;
        idle_cnt = regs.sleep_ticks;
        duty = '0;
        hold_pin = 1'b1;
    endfunction

    function automatic result_t dimmer_step(tick_t t);
        result_t     r;
        logic        pulse;
        logic        go;
        sleep_code_t sreq;
        wake_code_t  wcmd;
        int unsigned lp;
        pulse = 1'b0;
        sreq = SLEEP_NONE;
        wcmd = WAKE_NONE;
        lp = regs.long_press_ticks;
        if (t.button_edge)
        begin
            pending = 1'b1;
            idle_cnt = regs.sleep_ticks;
        end
        if (t.battery_event == BATT_LOW)
        begin
            mode_q = MODE_LOWBAT;
            hold_pin = 1'b0;
            lvl = '0;
            sweep_dn = 1'b0;
            duty = '0;
        end
        else if (t.battery_event == BATT_RECOVERED)
        begin
            wcmd = WAKE_STOP;
            mode_q = MODE_IDLE;
            duty = '0;
            hold_pin = 1'b1;
        end

        case (mode_q)
            MODE_IDLE: sreq = count_idle(STOP_REQ);
            MODE_FADEIN:
            begin
                go = ({1'b0, lvl} + 12'd1) < {1'b0, bright};
                if (lvl != LEVEL_TOP)
                    lvl = lvl + 11'd1;
                if (go)
                    duty = square_law(lvl);
                else
                    mode_q = MODE_ON;
            end
            MODE_ON: sreq = count_idle(SLEEP_REQ);
            MODE_FADEOUT:
            begin
                if (lvl > 11'd1)
                begin
                    lvl = lvl - 11'd1;
                    duty = square_law(lvl);
                end
                else
                begin
                    lvl = '0;
                    mode_q = MODE_IDLE;
                end
            end
            MODE_ADJUST:
            begin
                if (sweep_dn)
                begin
                    if (bright > {1'b0, regs.sweep_floor})
                    begin
                        bright = bright - 11'd1;
                        duty = square_law(bright);
                    end
                    else
                    begin
                        if (bright != '0)
                            bright = bright - 11'd1;
                        sweep_dn = 1'b0;
                    end
                end
                else
                begin
                    if (bright < FULL_SCALE)
                    begin
                        bright = bright + 11'd1;
                        duty = square_law(bright);
                    end
                    else
                    begin
                        if (bright != LEVEL_TOP)
                            bright = bright + 11'd1;
                        sweep_dn = 1'b1;
                    end
                end
            end
            default:
            begin
                if (breath_cnt > regs.breath_divider)
                begin
                    breath_cnt = '0;
                    if (sweep_dn)
                    begin
                        if (lvl > 11'd1)
                        begin
                            lvl = lvl - 11'd1;
                            duty = square_law(lvl);
                        end
                        else
                        begin
                            lvl = '0;
                            sweep_dn = 1'b0;
                            wcmd = WAKE_START;
                            sreq = STOP_REQ;
                        end
                    end
                    else
                    begin
                        if (lvl < {1'b0, regs.breath_peak})
                        begin
                            lvl = lvl + 11'd1;
                            duty = square_law(lvl);
                        end
                        else
                        begin
                            if (lvl != LEVEL_TOP)
                                lvl = lvl + 11'd1;
                            sweep_dn = 1'b1;
                        end
                    end
                end
                else
                    breath_cnt = breath_cnt + 5'd1;
            end
        endcase

        if (pending && !t.button_level)
        begin
            pending = 1'b0;
            if (hold_cnt > lp + 2)
            begin
                hold_cnt = '0;
                lvl = bright;
                duty = square_law(lvl);
                mode_q = MODE_ON;
            end
            else
            begin
                if (click_win != '0)
                    bright = FULL_SCALE;
                else
                    click_win = regs.double_click_ticks;
                mode_q = (mode_q == MODE_IDLE) ? MODE_FADEIN : MODE_FADEOUT;
            end
        end
        else if (pending)
        begin
            if (hold_cnt != HOLD_TOP)
                hold_cnt = hold_cnt + 16'd1;
            if (hold_cnt == lp + 1 && mode_q == MODE_ON)
            begin
                mode_q = MODE_ADJUST;
                bright = lvl;
            end
            if (hold_cnt > regs.power_off_ticks)
            begin
                pulse = 1'b1;
                pending = 1'b0;
                mode_q = MODE_IDLE;
                duty = '0;
                hold_pin = 1'b1;
            end
        end
        else
        begin
            hold_cnt = '0;
            if (click_win != '0)
                click_win = click_win - 8'd1;
        end

        r.pwm_duty = duty;
        r.hold_enable = hold_pin;
        r.hold_pulse = pulse;
        r.sleep_request = sreq;
        r.wake_timer_cmd = wcmd;
        r.mode_now = mode_q;
        return r;
    endfunction

    task automatic queue_tick(bit e, bit l, batt_code_t b);
        tick_t t;
        t.button_edge = e;
        t.button_level = l;
        t.battery_event = b;
        button_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic add_sequence();
        int kind;
        int n;
        int lp;
        int po;
        int cap;
        kind = $urandom_range(0, 99);
        lp = regs.long_press_ticks;
        po = regs.power_off_ticks;
        if (kind < 25)
        begin
            queue_tick(1'b1, 1'b0, BATT_NONE);
            repeat ($urandom_range(0, 6)) queue_tick(1'b0, 1'b0, BATT_NONE);
        end
        else if (kind < 35)
        begin
            queue_tick(1'b1, 1'b0, BATT_NONE);
            cap = regs.double_click_ticks + 2;
            if (cap > 12)
                cap = 12;
            repeat ($urandom_range(0, cap)) queue_tick(1'b0, 1'b0, BATT_NONE);
            queue_tick(1'b1, 1'($urandom_range(0, 1)), BATT_NONE);
        end
        else if (kind < 60)
        begin
            n = $urandom_range(0, 2);
            if (n == 1 && lp + 14 <= 120)
                n = $urandom_range(lp + 2, lp + 14);
            else if (n == 2 && po + 4 <= 120)
                n = $urandom_range(po, po + 4);
            else
                n = $urandom_range(1, (lp < 20) ? lp : 20);
            queue_tick(1'b1, 1'b1, BATT_NONE);
            repeat (n - 1) queue_tick(1'b0, 1'b1, BATT_NONE);
            queue_tick(1'b0, 1'b0, BATT_NONE);
        end
        else if (kind < 72)
        begin
            n = $urandom_range(1, 30);
            if ($urandom_range(0, 3) == 0 && regs.sleep_ticks <= 100)
                n = regs.sleep_ticks + 5;
            repeat (n) queue_tick(1'b0, 1'b0, BATT_NONE);
        end
        else if (kind < 82)
        begin
            queue_tick(1'b0, 1'b0, BATT_LOW);
            cap = 2 * (regs.breath_divider + 2) * (regs.breath_peak + 1) + 4;
            if (cap > 120)
                cap = 120;
            repeat ($urandom_range(5, cap)) queue_tick(1'b0, 1'b0, BATT_NONE);
            if ($urandom_range(0, 9) < 7)
                queue_tick(1'b0, 1'b0, BATT_RECOVERED);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 6) == 0) ? batt_code_t'($urandom_range(1, 3))
                                                      : BATT_NONE);
        end
    endtask

    task automatic add_random(int count);
        int target;
        target = ticks_queued + count;
        while (ticks_queued < target)
            add_sequence();
    endtask

    task automatic wait_drained();
        while (ticks_taken != ticks_queued || pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SLEEP_TICKS:  regs.sleep_ticks = data;
            CFG_DOUBLE_CLICK: regs.double_click_ticks = data[7:0];
            CFG_LONG_PRESS:   regs.long_press_ticks = data[14:0];
            CFG_POWER_OFF:    regs.power_off_ticks = data;
            CFG_SWEEP_FLOOR:  regs.sweep_floor = data[9:0];
            CFG_BREATH_PEAK:  regs.breath_peak = data[9:0];
            CFG_BREATH_DIV:   regs.breath_divider = data[3:0];
            default:          regs.initial_brightness = data[9:0];
        endcase
    endtask

    task automatic program_regs(int sleep_n, int dclick_n, int long_n, int power_n,
                                int floor_n, int peak_n, int div_n, int init_n);
        write_reg(CFG_SLEEP_TICKS, 16'(sleep_n));
        write_reg(CFG_DOUBLE_CLICK, 16'(dclick_n));
        write_reg(CFG_LONG_PRESS, 16'(long_n));
        write_reg(CFG_POWER_OFF, 16'(power_n));
        write_reg(CFG_SWEEP_FLOOR, 16'(floor_n));
        write_reg(CFG_BREATH_PEAK, 16'(peak_n));
        write_reg(CFG_BREATH_DIV, 16'(div_n));
        write_reg(CFG_INIT_BRIGHT, 16'(init_n));
        settings_used++;
    endtask

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_outputs.push_back(dimmer_step(cur));
                ticks_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left == 0 && !calm && $urandom_range(0, 11) == 0)
                    gap_left = $urandom_range(1, 18);
                if (gap_left > 0 || button_ticks.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur = button_ticks.pop_front();
                    in_valid <= 1'b1;
                    button_edge <= cur.button_edge;
                    button_level <= cur.button_level;
                    battery_event <= cur.battery_event;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $error("Result appeared with no tick request waiting for it.");
                    fail_count++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    check_field("pwm_duty", want.pwm_duty, pwm_duty);
                    check_field("hold_enable", want.hold_enable, hold_enable);
                    check_field("hold_pulse", want.hold_pulse, hold_pulse);
                    check_field("sleep_request", want.sleep_request, sleep_request);
                    check_field("wake_timer_cmd", want.wake_timer_cmd, wake_timer_cmd);
                    check_field("mode_now", want.mode_now, mode_now);
                    results_seen++;
                end
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial begin
        reset_dimmer();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: field extremes, both battery events, the unused
        // battery code and a second press inside the click window.
        queue_tick(1'b0, 1'b0, BATT_NONE);
        queue_tick(1'b0, 1'b0, BATT_UNUSED);
        queue_tick(1'b1, 1'b0, BATT_NONE);
        repeat (3) queue_tick(1'b0, 1'b0, BATT_NONE);
        queue_tick(1'b1, 1'b1, BATT_NONE);
        queue_tick(1'b0, 1'b1, BATT_NONE);
        queue_tick(1'b0, 1'b0, BATT_NONE);
        repeat (2) queue_tick(1'b0, 1'b0, BATT_NONE);
        queue_tick(1'b0, 1'b0, BATT_LOW);
        repeat (4) queue_tick(1'b0, 1'b0, BATT_NONE);
        queue_tick(1'b1, 1'b1, BATT_LOW);
        queue_tick(1'b0, 1'b0, BATT_RECOVERED);
        queue_tick(1'b1, 1'b1, BATT_RECOVERED);
        queue_tick(1'b0, 1'b1, BATT_UNUSED);
        queue_tick(1'b0, 1'b0, BATT_NONE);
        add_random(120);
        wait_drained();

        program_regs(20, 8, 6, 40, 30, 6, 2, 500);
        add_random(120);
        wait_drained();
        add_random(130);
        wait_drained();

        program_regs(1, 0, 1, 1, 0, 1, 0, 1);
        add_random(200);
        wait_drained();

        program_regs($urandom_range(3, 60), $urandom_range(0, 20), $urandom_range(1, 25),
                     $urandom_range(5, 90), $urandom_range(0, 1023), $urandom_range(1, 20),
                     $urandom_range(0, 15), $urandom_range(1, 1023));
        add_random(220);
        wait_drained();

        // Top settings but for the long press count, with one press held well below that count.
        program_regs(65535, 255, 30000, 65535, 1023, 1023, 15, 1023);
        queue_tick(1'b1, 1'b1, BATT_NONE);
        repeat (40) queue_tick(1'b0, 1'b1, BATT_NONE);
        queue_tick(1'b0, 1'b0, BATT_NONE);
        add_random(100);
        wait_drained();

        program_regs($urandom_range(3, 60), $urandom_range(0, 20), $urandom_range(1, 25),
                     $urandom_range(5, 90), $urandom_range(0, 1023), $urandom_range(1, 20),
                     $urandom_range(0, 15), $urandom_range(1, 1023));
        calm = 1'b1;
        add_random(200);
        wait_drained();
        repeat (16) @(posedge clk);

        $display("Checked %0d tick results over %0d register settings,", results_seen,
                 settings_used);
        $display("covering fades, adjust sweeps, breathing, timeouts and very long presses.");
        if (fail_count == 0)
            $display("** led_dimmer_button_controller: PASSED **");
        else
            $display("** led_dimmer_button_controller: FAILED **");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timeout: the run did not complete in the allowed time.");
        $display("** led_dimmer_button_controller: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/ldbc_pkg.sv
rtl/ldbc_cfg.sv
rtl/ldbc_core.sv
rtl/led_dimmer_button_controller.sv
dv/led_dimmer_button_controller_test.sv
